FILE: rtl/dltq_pkg.sv
// Shared constants, codes and payload types of the delta-list timer queue.
package dltq_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int TIME_WIDTH = 32;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int OUT_MAX    = 8;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCEL_OK = 3'd2,
    KIND_MISS      = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] period;
    logic        periodic;
    logic [2:0]  handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

FILE: rtl/delta_list_timer_queue.sv
// Delta-list timer queue: slot store, list sequencer and result buffer.
//
// Usage: one input channel (in_valid_i / in_stall_o / in_data_i) takes commands:
// tick, add timer, cancel timer. One output channel (out_valid_o / out_stall_i /
// out_data_o) returns result beats; the final beat of a command carries last.
// A beat moves at a rising edge with valid high and stall low.
// The block works on one command at a time and stalls its input until every
// result beat of that command has been taken.
// Cancel and a refused add give their beat in the cycle after acceptance.
// Add walks the delta list with one shared subtract-and-compare unit, one entry
// per cycle. Tick decrements the head, then pops one expired entry per step and
// closes the scan; each periodic entry is linked in again before the next pop.
// Then its fired beats follow, one per cycle while the receiver does not stall.
// A tick with nothing due gives no beat; it still runs the decrement and the scan.
// Ticks on an empty list and unused commands give no beat.
// When the receiver stalls, the current beat holds and the input stays stalled.
// Reset frees all slots and empties the list; no clearing pass is needed.
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LSTART = 3'd1;
  localparam logic [2:0] ST_LWALK  = 3'd2;
  localparam logic [2:0] ST_LFIN   = 3'd3;
  localparam logic [2:0] ST_TDEC   = 3'd4;
  localparam logic [2:0] ST_TPOP   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Slot store.
  logic [TIME_WIDTH-1:0] delta_q  [NUM_SLOTS];
  logic [TIME_WIDTH-1:0] delta_d  [NUM_SLOTS];
  logic [TIME_WIDTH-1:0] reload_q [NUM_SLOTS];
  logic [TIME_WIDTH-1:0] reload_d [NUM_SLOTS];
  logic [SLOT_W-1:0]     next_q   [NUM_SLOTS];
  logic [SLOT_W-1:0]     next_d   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  has_next_q, has_next_d;
  logic [NUM_SLOTS-1:0]  in_use_q, in_use_d;
  logic [NUM_SLOTS-1:0]  per_q, per_d;
  logic [NUM_SLOTS-1:0]  canc_q, canc_d;
  logic [SLOT_W-1:0]     head_q, head_d;
  logic                  nonempty_q, nonempty_d;

  // Sequencer and working registers.
  logic [2:0]            state_q, state_d;
  logic [TIME_WIDTH-1:0] w_q, w_d;          // delta of the entry being linked in
  logic [SLOT_W-1:0]     ins_q, ins_d;      // slot being linked in
  logic [SLOT_W-1:0]     cur_q, cur_d;      // walk position
  logic                  from_tick_q, from_tick_d;
  logic [CNT_W-1:0]      iter_q, iter_d;    // expiry loop count
  logic [CNT_W-1:0]      cnt_q, cnt_d;      // results buffered
  logic [SLOT_W-1:0]     oidx_q, oidx_d;    // result being presented

  res_t                  buf_q [OUT_MAX];
  res_t                  buf_d [OUT_MAX];

  // Shared subtract-and-compare unit.
  logic [SLOT_W-1:0]     rd_addr;
  logic [TIME_WIDTH-1:0] rd_val;
  logic                  rd_gt;
  logic [TIME_WIDTH-1:0] diff_rw;
  logic [TIME_WIDTH-1:0] diff_wr;

  // Free-slot search and command decode.
  logic [SLOT_W-1:0]     free_slot;
  logic                  free_found;
  logic [TIME_WIDTH-1:0] add_period;
  logic [SLOT_W-1:0]     pop_slot;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!in_use_q[j]) begin
        free_slot  = SLOT_W'(j);
        free_found = 1'b1;
      end
    end
  end

  assign add_period = (in_data_i.period == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(in_data_i.period);

  // The walk reads the successor of the current entry; every other step reads the head.
  assign rd_addr = (state_q == ST_LWALK) ? next_q[cur_q] : head_q;
  assign rd_val  = delta_q[rd_addr];
  assign rd_gt   = rd_val > w_q;
  assign diff_rw = rd_val - w_q;
  assign diff_wr = w_q - rd_val;
  assign pop_slot = head_q;

  always_comb begin
    delta_d     = delta_q;
    reload_d    = reload_q;
    next_d      = next_q;
    has_next_d  = has_next_q;
    in_use_d    = in_use_q;
    per_d       = per_q;
    canc_d      = canc_q;
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    state_d     = state_q;
    w_d         = w_q;
    ins_d       = ins_q;
    cur_d       = cur_q;
    from_tick_d = from_tick_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    oidx_d      = '0;
    buf_d       = buf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(in_data_i.mode))
            MODE_ADD: begin
              cnt_d = CNT_W'(1);
              if (free_found) begin
                // Claim the lowest free slot, then link it in.
                in_use_d[free_slot] = 1'b1;
                reload_d[free_slot] = add_period;
                per_d[free_slot]    = in_data_i.periodic;
                canc_d[free_slot]   = 1'b0;
                w_d                 = add_period;
                ins_d               = free_slot;
                from_tick_d         = 1'b0;
                buf_d[0]            = '{kind: KIND_ADDED, slot: free_slot};
                state_d             = ST_LSTART;
              end else begin
                buf_d[0] = '{kind: KIND_FULL, slot: '0};
                state_d  = ST_OUT;
              end
            end
            MODE_CANCEL: begin
              cnt_d = CNT_W'(1);
              if (in_use_q[in_data_i.handle]) begin
                canc_d[in_data_i.handle] = 1'b1;
                buf_d[0] = '{kind: KIND_CANCEL_OK, slot: in_data_i.handle};
              end else begin
                buf_d[0] = '{kind: KIND_MISS, slot: in_data_i.handle};
              end
              state_d = ST_OUT;
            end
            MODE_TICK: begin
              if (nonempty_q) begin
                w_d     = TIME_WIDTH'(1);
                cnt_d   = '0;
                iter_d  = '0;
                state_d = ST_TDEC;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LSTART: begin
        has_next_d[ins_q] = 1'b0;
        next_d[ins_q]     = '0;
        if (!nonempty_q) begin
          head_d     = ins_q;
          nonempty_d = 1'b1;
          state_d    = ST_LFIN;
        end else if (rd_gt) begin
          // New entry goes in front of the head.
          delta_d[head_q]   = diff_rw;
          next_d[ins_q]     = head_q;
          has_next_d[ins_q] = 1'b1;
          head_d            = ins_q;
          state_d           = ST_LFIN;
        end else begin
          w_d     = diff_wr;
          cur_d   = head_q;
          state_d = ST_LWALK;
        end
      end

      ST_LWALK: begin
        if (!has_next_q[cur_q]) begin
          next_d[cur_q]     = ins_q;
          has_next_d[cur_q] = 1'b1;
          state_d           = ST_LFIN;
        end else if (rd_gt) begin
          delta_d[rd_addr]  = diff_rw;
          next_d[ins_q]     = rd_addr;
          has_next_d[ins_q] = 1'b1;
          next_d[cur_q]     = ins_q;
          state_d           = ST_LFIN;
        end else begin
          w_d   = diff_wr;
          cur_d = rd_addr;
        end
      end

      ST_LFIN: begin
        delta_d[ins_q] = w_q;
        state_d        = from_tick_q ? ST_TPOP : ST_OUT;
      end

      ST_TDEC: begin
        if (rd_val != '0) begin
          delta_d[head_q] = diff_rw;
        end
        state_d = ST_TPOP;
      end

      ST_TPOP: begin
        if (iter_q == CNT_W'(NUM_SLOTS) || !nonempty_q ||
            cnt_q == CNT_W'(OUT_MAX) || rd_val != '0) begin
          state_d = (cnt_q != '0) ? ST_OUT : ST_IDLE;
        end else begin
          iter_d = iter_q + CNT_W'(1);
          if (!canc_q[pop_slot]) begin
            buf_d[cnt_q[SLOT_W-1:0]] = '{kind: KIND_FIRED, slot: pop_slot};
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (has_next_q[pop_slot]) begin
            head_d = next_q[pop_slot];
          end else begin
            nonempty_d = 1'b0;
          end
          if (per_q[pop_slot] && !canc_q[pop_slot]) begin
            // Re-arm with the full period.
            w_d         = reload_q[pop_slot];
            ins_d       = pop_slot;
            from_tick_d = 1'b1;
            state_d     = ST_LSTART;
          end else begin
            in_use_d[pop_slot]   = 1'b0;
            per_d[pop_slot]      = 1'b0;
            canc_d[pop_slot]     = 1'b0;
            has_next_d[pop_slot] = 1'b0;
            next_d[pop_slot]     = '0;
            delta_d[pop_slot]    = '0;
            reload_d[pop_slot]   = '0;
          end
        end
      end

      ST_OUT: begin
        oidx_d = oidx_q;
        if (!out_stall_i) begin
          if ({1'b0, oidx_q} == cnt_q - CNT_W'(1)) begin
            state_d = ST_IDLE;
            oidx_d  = '0;
          end else begin
            oidx_d = oidx_q + SLOT_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      has_next_q  <= '0;
      in_use_q    <= '0;
      per_q       <= '0;
      canc_q      <= '0;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      from_tick_q <= 1'b0;
      iter_q      <= '0;
      cnt_q       <= '0;
      oidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      has_next_q  <= has_next_d;
      in_use_q    <= in_use_d;
      per_q       <= per_d;
      canc_q      <= canc_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      from_tick_q <= from_tick_d;
      iter_q      <= iter_d;
      cnt_q       <= cnt_d;
      oidx_q      <= oidx_d;
    end
  end

  // Payload storage: every read is guarded by control state.
  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    reload_q <= reload_d;
    next_q   <= next_d;
    buf_q    <= buf_d;
    w_q      <= w_d;
    ins_q    <= ins_d;
    cur_q    <= cur_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign out_data_o.kind = buf_q[oidx_q].kind;
  assign out_data_o.slot = buf_q[oidx_q].slot;
  assign out_data_o.last = ({1'b0, oidx_q} == cnt_q - CNT_W'(1));

endmodule

FILE: sim/tb_delta_list_timer_queue.sv
`timescale 1ns / 1ps
// Testbench of the delta-list timer queue: directed and random commands, every beat checked.
module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  // Timer-list predictor and beat checker. Mirror the slot store and the delta list,
  // then queue the beats that each accepted command must produce.
  class timer_scoreboard;
    bit [TIME_WIDTH-1:0] delta_q  [NUM_SLOTS];
    bit [TIME_WIDTH-1:0] reload_q [NUM_SLOTS];
    bit [SLOT_W-1:0]     link_q   [NUM_SLOTS];
    bit                  has_link [NUM_SLOTS];
    bit                  busy     [NUM_SLOTS];
    bit                  rearm    [NUM_SLOTS];
    bit                  killed   [NUM_SLOTS];
    bit [SLOT_W-1:0]     head;
    bit                  nonempty;
    out_item_t           awaited_beats[$];
    int                  errors;

    function out_item_t beat_of(kind_e k, int unsigned s);
      out_item_t b;
      b.kind = k;
      b.slot = s[SLOT_W-1:0];
      b.last = 1'b0;
      return b;
    endfunction

    // Link slot s in after every entry that expires no later than it.
    function void insert_sorted(int unsigned s);
      int unsigned cur;
      int unsigned nxt;
      has_link[s] = 1'b0;
      link_q[s]   = '0;
      if (!nonempty) begin
        head     = s[SLOT_W-1:0];
        nonempty = 1'b1;
        return;
      end
      cur = 32'(head);
      if (delta_q[cur] > delta_q[s]) begin
        delta_q[cur] -= delta_q[s];
        link_q[s]   = cur[SLOT_W-1:0];
        has_link[s] = 1'b1;
        head        = s[SLOT_W-1:0];
        return;
      end
      delta_q[s] -= delta_q[cur];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!has_link[cur]) begin
          link_q[cur]   = s[SLOT_W-1:0];
          has_link[cur] = 1'b1;
          return;
        end
        nxt = 32'(link_q[cur]);
        if (delta_q[s] < delta_q[nxt]) begin
          delta_q[nxt] -= delta_q[s];
          link_q[s]   = nxt[SLOT_W-1:0];
          has_link[s] = 1'b1;
          link_q[cur] = s[SLOT_W-1:0];
          return;
        end
        delta_q[s] -= delta_q[nxt];
        cur = nxt;
      end
    endfunction

    // Predict the beats of one accepted command; return 1 when the block just drops it.
    function bit note_command(in_item_t cmd);
      out_item_t           beats[$];
      bit [TIME_WIDTH-1:0] p;
      int unsigned         s;
      mode_e               op;
      bit                  dropped;
      op      = mode_e'(cmd.mode);
      dropped = (op == MODE_NONE) || (op == MODE_TICK && !nonempty);
      case (op)
        MODE_ADD: begin
          p = cmd.period;
          if (p == '0) p = 1;
          s = NUM_SLOTS;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!busy[i]) s = i;
          if (s == NUM_SLOTS) begin
            beats.push_back(beat_of(KIND_FULL, 0));
          end else begin
            busy[s]     = 1'b1;
            delta_q[s]  = p;
            reload_q[s] = p;
            rearm[s]    = cmd.periodic;
            killed[s]   = 1'b0;
            insert_sorted(s);
            beats.push_back(beat_of(KIND_ADDED, s));
          end
        end
        MODE_CANCEL: begin
          s = 32'(cmd.handle);
          if (busy[s]) begin
            killed[s] = 1'b1;
            beats.push_back(beat_of(KIND_CANCEL_OK, s));
          end else begin
            beats.push_back(beat_of(KIND_MISS, s));
          end
        end
        MODE_TICK: begin
          if (nonempty) begin
            if (delta_q[head] > 0) delta_q[head] -= 1;
            for (int i = 0; i < NUM_SLOTS && nonempty && beats.size() < OUT_MAX; i++) begin
              s = 32'(head);
              if (delta_q[s] != 0) break;
              if (!killed[s]) beats.push_back(beat_of(KIND_FIRED, s));
              if (has_link[s]) head = link_q[s];
              else nonempty = 1'b0;
              if (rearm[s] && !killed[s]) begin
                delta_q[s] = reload_q[s];
                insert_sorted(s);
              end else begin
                busy[s]     = 1'b0;
                rearm[s]    = 1'b0;
                killed[s]   = 1'b0;
                has_link[s] = 1'b0;
                link_q[s]   = '0;
                delta_q[s]  = '0;
                reload_q[s] = '0;
              end
            end
          end
        end
        default: ;
      endcase
      if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) awaited_beats.push_back(beats[i]);
      return dropped;
    endfunction

    // Compare one accepted beat with the oldest awaited one.
    function void check_beat(out_item_t got);
      out_item_t want;
      if (awaited_beats.size() == 0) begin
        $error("unexpected beat: kind %0d slot %0d last %0d", got.kind, got.slot, got.last);
        errors++;
        return;
      end
      want = awaited_beats.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // Hold every input at a known value from time zero.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  timer_scoreboard sb;
  int unsigned     issued_count;
  int unsigned     beats_taken;
  bit              wide_period_used;

  delta_list_timer_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic in_item_t cmd_of(mode_e op, logic [31:0] period, logic periodic,
                                      logic [2:0] handle);
    in_item_t c;
    c.mode     = op;
    c.period   = period;
    c.periodic = periodic;
    c.handle   = handle;
    return c;
  endfunction

  // Draw one random command. Keep periods short so timers actually expire and free
  // their slots; allow a single full-width period, since such a timer never leaves.
  function automatic in_item_t random_command();
    in_item_t    c;
    int unsigned pick;
    int unsigned span;
    pick       = $urandom_range(0, 99);
    c.period   = $urandom();
    c.periodic = 1'($urandom_range(0, 1));
    c.handle   = 3'($urandom_range(0, 7));
    if (pick < 55)      c.mode = MODE_TICK;
    else if (pick < 80) c.mode = MODE_ADD;
    else if (pick < 96) c.mode = MODE_CANCEL;
    else                c.mode = MODE_NONE;
    if (c.mode == MODE_ADD) begin
      c.periodic = ($urandom_range(0, 2) == 0);
      span       = $urandom_range(0, 199);
      if (span == 0 && !wide_period_used) wide_period_used = 1'b1;
      else if (span < 20) c.period = '0;
      else if (span < 40) c.period = $urandom_range(13, 60);
      else                c.period = $urandom_range(1, 12);
    end
    return c;
  endfunction

  // Offer one command beat after a random gap and hold it until the block takes it.
  // Leave valid high on acceptance so a back-to-back beat needs no second assignment.
  task automatic send_command(input in_item_t cmd, output bit dropped);
    int unsigned gap;
    // Run every 100 commands through a stretch of 30 with no gaps at all.
    gap = (issued_count % 100 >= 70) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    dropped = sb.note_command(cmd);
    issued_count++;
  endtask

  // Result side: stall for a random number of cycles, then take the next beat.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (beats_taken == 40)
        gap = 300;                  // long hold: let the block fill up and stall its input
      else if (beats_taken % 128 < 32)
        gap = 0;                    // run without stalls for a while
      else
        gap = $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_beat(out_data_o);
      beats_taken++;
    end
  end

  // Main sequence: reset, directed commands, random commands, drain.
  initial begin
    bit          dropped;
    int unsigned useful;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick on an empty list and an unused mode: both dropped without a beat.
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    send_command(cmd_of(MODE_NONE, '1, 1'b1, 3'd7), dropped);
    // Cancel of a free slot misses.
    send_command(cmd_of(MODE_CANCEL, '0, 1'b0, 3'd7), dropped);
    // Zero period is raised to one tick: fires on the next tick.
    send_command(cmd_of(MODE_ADD, '0, 1'b0, 3'd0), dropped);
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    // Fill every slot with the same expiry, odd slots periodic; then one add too many.
    for (int i = 0; i < NUM_SLOTS; i++)
      send_command(cmd_of(MODE_ADD, 32'd2, i[0], 3'd0), dropped);
    send_command(cmd_of(MODE_ADD, 32'd5, 1'b0, 3'd0), dropped);
    // All eight expire in one tick: the widest burst of fired beats.
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    // Cancel a re-armed periodic timer twice; its expiry then passes silently.
    send_command(cmd_of(MODE_CANCEL, '0, 1'b0, 3'd3), dropped);
    send_command(cmd_of(MODE_CANCEL, '0, 1'b0, 3'd3), dropped);
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);
    // Cancel of slot 0, now free again; then the longest possible period.
    send_command(cmd_of(MODE_CANCEL, '1, 1'b1, 3'd0), dropped);
    send_command(cmd_of(MODE_ADD, '1, 1'b1, 3'd0), dropped);
    send_command(cmd_of(MODE_TICK, '0, 1'b0, 3'd0), dropped);

    // Random commands; dropped ones do not count.
    useful = 0;
    while (useful < 400) begin
      send_command(random_command(), dropped);
      if (!dropped) useful++;
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every awaited beat, then give stray beats time to show up.
    while (sb.awaited_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_delta_list_timer_queue passed");
    end else begin
      $display("tb_delta_list_timer_queue failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #6000000;
    $display("tb_delta_list_timer_queue failed");
    $finish;
  end

endmodule
